@@ src/kvm_pkg.sv @@
// ----------------------------------------------------------------------------
// kvm_pkg: shared constants and types of the keyed sample voice mixer
// Sizes of the key table, the sample memory and the mix accumulator, plus the
// control group that the sequencer hands to the accumulator.
// ----------------------------------------------------------------------------
package kvm_pkg;

  // Key slots; one voice per slot.
  localparam int NUM_KEYS = 256;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Sample memory: one stereo frame per address, addresses wrap at its size.
  localparam int ADDR_W        = 18;
  localparam int SAMPLE_FRAMES = 1 << ADDR_W;

  localparam int LEN_W    = 19;
  localparam int SMP_W    = 16;
  localparam int MIX_W    = 24;
  // Enough headroom that a full scan of every key never overflows.
  localparam int ACC_W    = SMP_W + KEY_W + 1;

  localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

  // Sequencer to accumulator.
  typedef struct packed {
    logic clear;   // start of a tick: zero both sums
    logic add;     // add the current sample pair
    logic finish;  // saturate and present the result
  } acc_ctl_t;

endpackage

@@ src/kvm_accum.sv @@
// ----------------------------------------------------------------------------
// kvm_accum: stereo mix accumulator
// Adds one stereo sample pair per cycle, while add is set, into two wide sums, then clamps each
// sum to 24 bits and drives the result strobe for one cycle.
// ----------------------------------------------------------------------------
module kvm_accum
  import kvm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  acc_ctl_t                ctl,
  input  logic signed [SMP_W-1:0] smp_left,
  input  logic signed [SMP_W-1:0] smp_right,
  output logic                    out_valid,
  output logic signed [MIX_W-1:0] out_mix_left,
  output logic signed [MIX_W-1:0] out_mix_right,
  output logic                    out_clipped
);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'((1 << (MIX_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(1 << (MIX_W - 1));
  localparam logic signed [MIX_W-1:0] MIX_HI = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic signed [MIX_W-1:0] MIX_LO = {1'b1, {(MIX_W-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  logic signed [ACC_W-1:0] acc_l_nxt, acc_r_nxt;
  logic                    valid_r;
  logic signed [MIX_W-1:0] mix_l_r, mix_r_r;
  logic                    clip_r;
  logic signed [MIX_W-1:0] sat_l, sat_r;
  logic                    clip_l, clip_rt;

  always_comb begin
    priority if (ctl.clear) begin
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else if (ctl.add) begin
      acc_l_nxt = acc_l_r + ACC_W'(smp_left);
      acc_r_nxt = acc_r_r + ACC_W'(smp_right);
    end else begin
      acc_l_nxt = acc_l_r;
      acc_r_nxt = acc_r_r;
    end
  end

  always_comb begin
    clip_l  = 1'b0;
    clip_rt = 1'b0;
    priority if (acc_l_r > ACC_HI) begin
      sat_l  = MIX_HI;
      clip_l = 1'b1;
    end else if (acc_l_r < ACC_LO) begin
      sat_l  = MIX_LO;
      clip_l = 1'b1;
    end else begin
      sat_l = acc_l_r[MIX_W-1:0];
    end
    priority if (acc_r_r > ACC_HI) begin
      sat_r   = MIX_HI;
      clip_rt = 1'b1;
    end else if (acc_r_r < ACC_LO) begin
      sat_r   = MIX_LO;
      clip_rt = 1'b1;
    end else begin
      sat_r = acc_r_r[MIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    if (ctl.finish) begin
      mix_l_r <= sat_l;
      mix_r_r <= sat_r;
      clip_r  <= clip_l | clip_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.finish;
    end
  end

  assign out_valid     = valid_r;
  assign out_mix_left  = mix_l_r;
  assign out_mix_right = mix_r_r;
  assign out_clipped   = clip_r;

endmodule

@@ src/keyed_sample_voice_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_sample_voice_mixer_unit: polyphonic sample player, one voice per key
// Stores stereo frames and key definitions, restarts voices on trigger, and on
// each tick scans every key slot to build one saturated stereo output frame.
//
//   channel   ports                     handshake
//   input     start/busy, in_*          taken when start && !busy
//   result    out_valid, out_*          one-cycle strobe, no backpressure
//
// Load, define and trigger leave busy low. A tick holds busy while the
// sequencer walks the key, position and sample memories one key slot per cycle
// through a three-stage read pipeline; the result strobe rises in the same
// cycle that busy falls.
// Reset clears the voice active bits and the sequencer; the memories are not
// cleared and need no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module keyed_sample_voice_mixer_unit
  import kvm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_mode,
  input  logic [7:0]              in_key_index,
  input  logic [ADDR_W-1:0]       in_address,
  input  logic [LEN_W-1:0]        in_length,
  input  logic signed [SMP_W-1:0] in_left_in,
  input  logic signed [SMP_W-1:0] in_right_in,
  output logic                    out_valid,
  output logic signed [MIX_W-1:0] out_mix_left,
  output logic signed [MIX_W-1:0] out_mix_right,
  output logic                    out_clipped
);

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_DEFINE  = 2'd1,
    MODE_TRIGGER = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  // Memories
  logic [2*SMP_W-1:0] smp_mem   [SAMPLE_FRAMES];
  logic [ADDR_W-1:0]  kstart_mem[NUM_KEYS];
  logic [LEN_W-1:0]   klen_mem  [NUM_KEYS];
  logic [LEN_W-1:0]   pos_mem   [NUM_KEYS];
  logic [NUM_KEYS-1:0] active_r;

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   idx_r, idx_nxt;

  // Stage B: key data read back
  logic               vb_r;
  logic               act_b_r;
  logic [KEY_W-1:0]   kb_r;
  logic [ADDR_W-1:0]  ks_q_r;
  logic [LEN_W-1:0]   kl_q_r;
  logic [LEN_W-1:0]   pos_q_r;

  // Stage C: sample read back
  logic               vc_r;
  logic               hit_c_r;
  logic [2*SMP_W-1:0] smp_q_r;

  logic               accept;
  mode_t              mode;
  logic               key_ok;
  logic [31:0]        key_ext;
  logic [KEY_W-1:0]   key_sel;
  logic               in_rng;
  logic [LEN_W-1:0]   pos_inc;
  logic               drop;
  logic [ADDR_W-1:0]  play_addr;
  logic               pos_we;
  logic [KEY_W-1:0]   pos_wa;
  logic [LEN_W-1:0]   pos_wd;
  acc_ctl_t           acc_ctl;

  assign accept  = start && !busy;
  assign mode    = mode_t'(in_mode);
  assign key_ext = 32'(in_key_index);
  assign key_ok  = key_ext < 32'(NUM_KEYS);
  assign key_sel = key_ext[KEY_W-1:0];
  assign busy    = (state_r != ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && mode == MODE_TICK) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_KEY) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!vb_r && !vc_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      vb_r    <= (state_r == ST_SCAN);
      vc_r    <= vb_r;
    end
  end

  // Stage A: read key definition, position and active bit of the slot
  always_ff @(posedge clk) begin
    ks_q_r  <= kstart_mem[idx_r];
    kl_q_r  <= klen_mem[idx_r];
    pos_q_r <= pos_mem[idx_r];
    act_b_r <= active_r[idx_r];
    kb_r    <= idx_r;
  end

  // Stage B: range check, advance, sample fetch
  assign in_rng    = pos_q_r < kl_q_r;
  assign pos_inc   = (pos_q_r != POS_MAX) ? pos_q_r + 1'b1 : pos_q_r;
  assign drop      = pos_inc >= kl_q_r;
  assign play_addr = ks_q_r + pos_q_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    smp_q_r <= smp_mem[play_addr];
    hit_c_r <= act_b_r && in_rng;
  end

  // Position write port: scan advance or trigger restart
  always_comb begin
    pos_we = 1'b0;
    pos_wa = kb_r;
    pos_wd = pos_inc;
    priority if (vb_r && act_b_r) begin
      pos_we = 1'b1;
    end else if (accept && mode == MODE_TRIGGER && key_ok) begin
      pos_we = 1'b1;
      pos_wa = key_sel;
      pos_wd = '0;
    end else begin
      pos_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD) begin
      smp_mem[in_address] <= {in_left_in, in_right_in};
    end
    if (accept && mode == MODE_DEFINE && key_ok) begin
      kstart_mem[key_sel] <= in_address;
      klen_mem[key_sel]   <= in_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (vb_r && act_b_r && drop) begin
        active_r[kb_r] <= 1'b0;
      end
      if (accept && mode == MODE_TRIGGER && key_ok) begin
        active_r[key_sel] <= 1'b1;
      end
    end
  end

  // Stage C: accumulate
  always_comb begin
    acc_ctl.clear  = accept && mode == MODE_TICK;
    acc_ctl.add    = vc_r && hit_c_r;
    acc_ctl.finish = (state_r == ST_DRAIN) && !vb_r && !vc_r;
  end

  kvm_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (acc_ctl),
    .smp_left     (smp_q_r[2*SMP_W-1:SMP_W]),
    .smp_right    (smp_q_r[SMP_W-1:0]),
    .out_valid    (out_valid),
    .out_mix_left (out_mix_left),
    .out_mix_right(out_mix_right),
    .out_clipped  (out_clipped)
  );

  // Checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !vb_r && !vc_r)
    else $error("read pipeline not empty while idle");

  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode == MODE_TICK |=> state_r == ST_SCAN && idx_r == '0)
    else $error("tick did not start the scan at slot zero");

  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DRAIN))
    else $error("result strobe without a finished scan");

  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

@@ tb/keyed_sample_voice_mixer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_sample_voice_mixer_unit_tb: self-checking bench for the voice mixer
// Drives load, define, trigger and tick items through the start/busy port.
// A local copy of the sample memory, key table and voice state predicts the
// mix frame of each random tick; script and chord ticks carry hand-written
// frames, and each strobed result is checked against its frame. A short
// hand-written script and a full-scale chord come first, then random traffic.
// Before each random tick, every unwritten frame a playing voice reads is loaded.
// ----------------------------------------------------------------------------
module keyed_sample_voice_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvm_pkg::*;

  localparam int IDLE_PCT       = 18;
  localparam int TOTAL_ITEMS    = 1200;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_DEFINE  = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [7:0]              key;
    logic [ADDR_W-1:0]       addr;
    logic [LEN_W-1:0]        len;
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } cmd_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] left;
    logic signed [MIX_W-1:0] right;
    logic                    clip;
  } mix_t;

  typedef struct packed {
    cmd_t c;
    logic typed;
    mix_t m;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_mode = '0;
  logic [7:0]              in_key_index = '0;
  logic [ADDR_W-1:0]       in_address = '0;
  logic [LEN_W-1:0]        in_length = '0;
  logic signed [SMP_W-1:0] in_left_in = '0;
  logic signed [SMP_W-1:0] in_right_in = '0;
  logic                    out_valid;
  logic signed [MIX_W-1:0] out_mix_left;
  logic signed [MIX_W-1:0] out_mix_right;
  logic                    out_clipped;

  keyed_sample_voice_mixer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_key_index  (in_key_index),
    .in_address    (in_address),
    .in_length     (in_length),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_mix_left  (out_mix_left),
    .out_mix_right (out_mix_right),
    .out_clipped   (out_clipped)
  );

  always #4 clk = ~clk;

  // Shadow of the block's memories and voice state
  bit [2*SMP_W-1:0] frame_mem     [SAMPLE_FRAMES];
  bit               frame_written [SAMPLE_FRAMES];
  bit [ADDR_W-1:0]  key_base      [NUM_KEYS];
  bit [LEN_W-1:0]   key_len       [NUM_KEYS];
  bit               key_known     [NUM_KEYS];
  bit [LEN_W-1:0]   voice_pos     [NUM_KEYS];
  bit               voice_on      [NUM_KEYS];

  mix_t        pending_mix[$];
  script_row_t script[$];
  bit          errors_seen = 1'b0;
  bit          idle_ok = 1'b1;
  int          quiet_cycles = 0;
  int          items_sent = 0;

  function automatic cmd_t mk(op_e op, int key, int addr, int len, int l, int r);
    cmd_t c;
    c.op    = op;
    c.key   = key[7:0];
    c.addr  = addr[ADDR_W-1:0];
    c.len   = len[LEN_W-1:0];
    c.left  = l[SMP_W-1:0];
    c.right = r[SMP_W-1:0];
    return c;
  endfunction

  function automatic void row(op_e op, int key, int addr, int len, int l, int r,
                              bit typed, int el, int er);
    script_row_t t;
    t.c       = mk(op, key, addr, len, l, r);
    t.typed   = typed;
    t.m.left  = el[MIX_W-1:0];
    t.m.right = er[MIX_W-1:0];
    t.m.clip  = 1'b0;
    script.insert(script.size(), t);
  endfunction

  // Sum every playing voice, then advance and retire voices as the block does
  function automatic mix_t mix_next_frame();
    longint           sum_l, sum_r, hi, lo;
    mix_t             f;
    bit [2*SMP_W-1:0] w;
    bit [ADDR_W-1:0]  a;
    int               k;
    sum_l = 0;
    sum_r = 0;
    hi    = (longint'(1) << (MIX_W - 1)) - 1;
    lo    = -(longint'(1) << (MIX_W - 1));
    for (k = 0; k < NUM_KEYS; k++) begin
      if (voice_on[k]) begin
        if (voice_pos[k] < key_len[k]) begin
          a     = ADDR_W'(key_base[k] + voice_pos[k]);
          w     = frame_mem[a];
          sum_l += $signed(w[2*SMP_W-1:SMP_W]);
          sum_r += $signed(w[SMP_W-1:0]);
        end
        if (voice_pos[k] != POS_MAX)
          voice_pos[k]++;
        if (voice_pos[k] >= key_len[k])
          voice_on[k] = 1'b0;
      end
    end
    f.clip = 1'b0;
    if (sum_l > hi) begin
      sum_l  = hi;
      f.clip = 1'b1;
    end else if (sum_l < lo) begin
      sum_l  = lo;
      f.clip = 1'b1;
    end
    if (sum_r > hi) begin
      sum_r  = hi;
      f.clip = 1'b1;
    end else if (sum_r < lo) begin
      sum_r  = lo;
      f.clip = 1'b1;
    end
    f.left  = sum_l[MIX_W-1:0];
    f.right = sum_r[MIX_W-1:0];
    return f;
  endfunction

  // Present one item, hold it until taken, then update the shadow state
  task automatic issue(cmd_t c, bit typed, mix_t typed_frame);
    mix_t f;
    while (idle_ok && $urandom_range(0, 99) < IDLE_PCT)
      @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start        <= 1'b1;
    in_mode      <= c.op;
    in_key_index <= c.key;
    in_address   <= c.addr;
    in_length    <= c.len;
    in_left_in   <= c.left;
    in_right_in  <= c.right;
    do @(posedge clk); while (busy);
    items_sent++;
    case (c.op)
      OP_LOAD: begin
        frame_mem[c.addr]     = {c.left, c.right};
        frame_written[c.addr] = 1'b1;
      end
      OP_DEFINE: begin
        if (c.key < NUM_KEYS) begin
          key_base[c.key]  = c.addr;
          key_len[c.key]   = c.len;
          key_known[c.key] = 1'b1;
        end
      end
      OP_TRIGGER: begin
        if (c.key < NUM_KEYS) begin
          voice_pos[c.key] = '0;
          voice_on[c.key]  = 1'b1;
        end
      end
      default: begin
        f = mix_next_frame();
        pending_mix.insert(pending_mix.size(), typed ? typed_frame : f);
      end
    endcase
  endtask

  function automatic logic signed [SMP_W-1:0] rand_smp();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic define_key(int k);
    int base, len, pick;
    base = ($urandom_range(0, 9) == 0) ? $urandom_range(SAMPLE_FRAMES - 8, SAMPLE_FRAMES - 1)
                                       : $urandom_range(0, SAMPLE_FRAMES - 1);
    pick = $urandom_range(0, 99);
    if (pick < 6)
      len = 0;
    else if (pick == 6)
      len = SAMPLE_FRAMES;
    else if (pick == 7)
      len = $urandom_range(1000, SAMPLE_FRAMES);
    else
      len = $urandom_range(1, 24);
    issue(mk(OP_DEFINE, k, base, len, rand_smp(), rand_smp()), 1'b0, '0);
  endtask

  // Load any unwritten frame a playing voice is about to read, then tick
  task automatic play_frame();
    bit [ADDR_W-1:0] a;
    int              k;
    for (k = 0; k < NUM_KEYS; k++) begin
      if (voice_on[k] && voice_pos[k] < key_len[k]) begin
        a = ADDR_W'(key_base[k] + voice_pos[k]);
        if (!frame_written[a])
          issue(mk(OP_LOAD, $urandom, a, $urandom, rand_smp(), rand_smp()), 1'b0, '0);
      end
    end
    issue(mk(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_mix
    mix_t want;
    if (rst_n && out_valid) begin
      if (pending_mix.size() == 0) begin
        $error("out_valid with no mix frame expected");
        errors_seen = 1'b1;
      end else begin
        want = pending_mix.pop_front();
        if (out_mix_left !== want.left) begin
          $error("out_mix_left: expected %0d, got %0d", want.left, out_mix_left);
          errors_seen = 1'b1;
        end
        if (out_mix_right !== want.right) begin
          $error("out_mix_right: expected %0d, got %0d", want.right, out_mix_right);
          errors_seen = 1'b1;
        end
        if (out_clipped !== want.clip) begin
          $error("out_clipped: expected %0d, got %0d", want.clip, out_clipped);
          errors_seen = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("keyed_sample_voice_mixer_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    script_row_t t;
    mix_t        full;
    int          k, pick, a;

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    //   op          key addr    len            left    right   typed  mix_l   mix_r
    row(OP_TICK,      0, 0,      0,             0,      0,      1'b1,  0,      0);
    row(OP_LOAD,      0, 0,      0,             32767,  -32768, 1'b0,  0,      0);
    row(OP_LOAD,      0, 262143, 0,             -32768, 32767,  1'b0,  0,      0);
    row(OP_LOAD,      0, 1,      0,             21845,  -21846, 1'b0,  0,      0);
    row(OP_LOAD,      0, 2,      0,             -21846, 21845,  1'b0,  0,      0);
    // key 0 wraps past the top of memory; key 255 has no frames
    row(OP_DEFINE,    0, 262143, 3,             0,      0,      1'b0,  0,      0);
    row(OP_DEFINE,  255, 0,      0,             0,      0,      1'b0,  0,      0);
    row(OP_TRIGGER,   0, 0,      0,             0,      0,      1'b0,  0,      0);
    row(OP_TRIGGER, 255, 0,      0,             0,      0,      1'b0,  0,      0);
    row(OP_TICK,      0, 0,      0,             0,      0,      1'b1,  -32768, 32767);
    row(OP_TICK,      0, 0,      0,             0,      0,      1'b1,  32767,  -32768);
    // retrigger while playing: back to the first frame
    row(OP_TRIGGER,   0, 0,      0,             0,      0,      1'b0,  0,      0);
    row(OP_TICK,      0, 0,      0,             0,      0,      1'b1,  -32768, 32767);
    // redefine while playing, longest sound; key 1 cancels it to -1
    row(OP_DEFINE,    0, 1,      SAMPLE_FRAMES, 0,      0,      1'b0,  0,      0);
    row(OP_DEFINE,    1, 1,      1,             0,      0,      1'b0,  0,      0);
    row(OP_TRIGGER,   1, 0,      0,             0,      0,      1'b0,  0,      0);
    row(OP_TICK,      0, 0,      0,             0,      0,      1'b1,  -1,     -1);

    foreach (script[i]) begin
      t = script[i];
      issue(t.c, t.typed, t.m);
    end

    // Every key on one frame at full scale: the left sum lands on the 24-bit minimum, the right just below the maximum
    issue(mk(OP_LOAD, 0, 100, 0, -32768, 32767), 1'b0, '0);
    for (k = 0; k < NUM_KEYS; k++)
      issue(mk(OP_DEFINE, k, 100, 1, 0, 0), 1'b0, '0);
    for (k = 0; k < NUM_KEYS; k++)
      issue(mk(OP_TRIGGER, k, 0, 0, 0, 0), 1'b0, '0);
    full.left  = -24'sd8388608;
    full.right = 24'sd8388352;
    full.clip  = 1'b0;
    issue(mk(OP_TICK, 0, 0, 0, 0, 0), 1'b1, full);

    // hold off until the chord has come back
    @(negedge clk) start <= 1'b0;
    wait (pending_mix.size() == 0);

    while (items_sent < TOTAL_ITEMS) begin
      idle_ok = !(items_sent >= 800 && items_sent < 1000);
      pick    = $urandom_range(0, 99);
      if (pick < 12) begin
        k = $urandom_range(0, NUM_KEYS - 1);
        if (key_known[k] && $urandom_range(0, 1))
          a = key_base[k] + $urandom_range(0, 15);
        else
          a = $urandom_range(0, SAMPLE_FRAMES - 1);
        issue(mk(OP_LOAD, $urandom, a, $urandom, rand_smp(), rand_smp()), 1'b0, '0);
      end else if (pick < 30) begin
        define_key($urandom_range(0, NUM_KEYS - 1));
      end else if (pick < 60) begin
        k = $urandom_range(0, NUM_KEYS - 1);
        if (!key_known[k])
          define_key(k);
        issue(mk(OP_TRIGGER, k, $urandom, $urandom, $urandom, $urandom), 1'b0, '0);
      end else begin
        play_frame();
      end
    end

    @(negedge clk) start <= 1'b0;
    wait (pending_mix.size() == 0);
    repeat (NUM_KEYS + 8) @(posedge clk);
    if (!errors_seen && pending_mix.size() == 0)
      $display("keyed_sample_voice_mixer_unit_tb: clean");
    else
      $display("keyed_sample_voice_mixer_unit_tb: errors");
    $finish;
  end

endmodule
